/* rtl/poi_pkg.sv */
package poi_pkg;

  // binary angle of a quarter turn, used to turn a sine lookup into a cosine
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // 65536 / (2*pi) in Q16, converts radians to binary angle units
  localparam logic signed [31:0] TURN_PER_RAD_Q16 = 32'sd683565276;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned QUARTER_Q30 = 64'd1073741824;

  // (2n)(2n+1) for the odd taylor terms x^3 .. x^11
  localparam longint unsigned SERIES_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INTERVAL_LIMIT    = 2'd0,
    REG_FALLBACK_INTERVAL = 2'd1
  } cfg_reg_t;

  // operand pairs fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_VX_COSQ,
    MUL_VY_SIN,
    MUL_VX_SIN,
    MUL_VY_COS,
    MUL_SX_DT,
    MUL_SY_DT,
    MUL_WZ_DT,
    MUL_P_K
  } mul_src_t;

  // angle presented to the sine table
  typedef enum logic [1:0] {
    ROM_HEAD,
    ROM_HEAD_COS,
    ROM_HALF,
    ROM_HALF_COS
  } rom_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_SIN,
    ST_RD_COS,
    ST_MUL_XC,
    ST_MUL_YS,
    ST_MUL_XS,
    ST_MUL_YC,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_MUL_WT,
    ST_MUL_WK,
    ST_HEAD,
    ST_RD_QZ,
    ST_RD_QW,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    mul_src_t mul_src;
    rom_src_t rom_src;
    logic     cap_sin;
    logic     cap_cos;
    logic     sumx_load;
    logic     sumx_sub;
    logic     sumy_load;
    logic     sumy_add;
    logic     posx_upd;
    logic     posy_upd;
    logic     head_upd;
    logic     out_load;
  } ctrl_t;

  // sin(pi/2 * r / 2^30) in Q1.14, integer series, evaluated at elaboration
  function automatic longint quarter_sine(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 0; n < 5; n++) begin
      term = (term * x2) >> 30;
      term = term / SERIES_DIV[n];
      if ((n & 1) == 0) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd32768) >>> 16;
    if (sum > 16384) sum = 16384;
    return sum;
  endfunction

  // sine of a 32-bit phase (full turn = 2^32), Q1.14
  function automatic logic signed [15:0] sine_of_phase(logic [31:0] phase);
    longint unsigned r;
    longint          q;
    r = {34'd0, phase[29:0]};
    if (phase[30]) r = QUARTER_Q30 - r;
    q = quarter_sine(r);
    if (phase[31]) q = -q;
    return 16'(q);
  endfunction

endpackage

/* rtl/poi_sine_rom.sv */
module poi_sine_rom import poi_pkg::*; #(
  parameter int TRIG_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic [15:0]        angle,
  output logic signed [15:0] q
);

  localparam int IDX_W = $clog2(TRIG_TABLE_DEPTH);

  logic signed [15:0] lut [TRIG_TABLE_DEPTH];
  logic [31:0]        scaled;
  logic [IDX_W-1:0]   idx;
  logic signed [15:0] q_r;

  for (genvar gi = 0; gi < TRIG_TABLE_DEPTH; gi++) begin : g_lut
    localparam logic [63:0] PHASE = (64'(gi) << 32) / TRIG_TABLE_DEPTH;
    localparam logic signed [15:0] VAL = sine_of_phase(PHASE[31:0]);
    assign lut[gi] = VAL;
  end

  // entry index = angle * depth / 65536
  assign scaled = 32'(angle) * 32'(TRIG_TABLE_DEPTH);
  assign idx    = scaled[16 +: IDX_W];

  always_ff @(posedge clk) begin
    q_r <= lut[idx];
  end

  assign q = q_r;

endmodule

/* rtl/poi_mul.sv */
module poi_mul import poi_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(a) * 64'(b);
  end

  assign prod = prod_r;

endmodule

/* rtl/poi_seq.sv */
module poi_seq import poi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  logic  out_free,
  output logic  in_ready,
  output ctrl_t ctrl
);

  seq_state_t state_r;
  seq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    ctrl.mul_src = MUL_VX_COSQ;
    ctrl.rom_src = ROM_HEAD;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) state_nxt = ST_RD_SIN;
      end
      ST_RD_SIN: begin
        ctrl.rom_src = ROM_HEAD;
        state_nxt    = ST_RD_COS;
      end
      ST_RD_COS: begin
        ctrl.rom_src = ROM_HEAD_COS;
        ctrl.cap_sin = 1'b1;
        state_nxt    = ST_MUL_XC;
      end
      ST_MUL_XC: begin
        ctrl.mul_src = MUL_VX_COSQ;
        ctrl.cap_cos = 1'b1;
        state_nxt    = ST_MUL_YS;
      end
      ST_MUL_YS: begin
        ctrl.mul_src   = MUL_VY_SIN;
        ctrl.sumx_load = 1'b1;
        state_nxt      = ST_MUL_XS;
      end
      ST_MUL_XS: begin
        ctrl.mul_src  = MUL_VX_SIN;
        ctrl.sumx_sub = 1'b1;
        state_nxt     = ST_MUL_YC;
      end
      ST_MUL_YC: begin
        ctrl.mul_src   = MUL_VY_COS;
        ctrl.sumy_load = 1'b1;
        state_nxt      = ST_MUL_DX;
      end
      ST_MUL_DX: begin
        ctrl.mul_src  = MUL_SX_DT;
        ctrl.sumy_add = 1'b1;
        state_nxt     = ST_MUL_DY;
      end
      ST_MUL_DY: begin
        ctrl.mul_src  = MUL_SY_DT;
        ctrl.posx_upd = 1'b1;
        state_nxt     = ST_MUL_WT;
      end
      ST_MUL_WT: begin
        ctrl.mul_src  = MUL_WZ_DT;
        ctrl.posy_upd = 1'b1;
        state_nxt     = ST_MUL_WK;
      end
      ST_MUL_WK: begin
        ctrl.mul_src = MUL_P_K;
        state_nxt    = ST_HEAD;
      end
      ST_HEAD: begin
        ctrl.head_upd = 1'b1;
        state_nxt     = ST_RD_QZ;
      end
      ST_RD_QZ: begin
        ctrl.rom_src = ROM_HALF;
        state_nxt    = ST_RD_QW;
      end
      ST_RD_QW: begin
        ctrl.rom_src = ROM_HALF_COS;
        ctrl.cap_sin = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        ctrl.rom_src = ROM_HALF_COS;
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/planar_odometry_integrator.sv */
// planar odometry integrator: takes a new transaction only in the idle state, so one is
// processed at a time; the sequencer steps through the 8 products that share one
// 32x32 multiplier and the 4 reads of the single-port sine table, then waits for out_free
// the output register holds a finished result while the next transaction is taken
// reset (rst_n low, synchronous) clears position, heading and the sequencer, and loads
// interval_limit = 32768 and fallback_interval = 6554
module planar_odometry_integrator import poi_pkg::*; #(
  parameter int TRIG_TABLE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // forward_speed, lateral_speed, turn_rate, elapsed_time (16 bits each, low to high)
  input  logic [63:0]            in_tdata,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // position_x (32), position_y (32), heading_angle, quat_z, quat_w, interval_used (16 each)
  output logic [127:0]           out_tdata,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_wdata
);

  // configuration registers
  logic [15:0] limit_r;
  logic [15:0] fallback_r;

  // captured command
  logic signed [15:0] vx_r;
  logic signed [15:0] vy_r;
  logic signed [15:0] wz_r;
  logic [15:0]        dt_r;
  logic [15:0]        dt_nxt;

  // trig samples and rotated velocity sums
  logic signed [15:0] sin_r;
  logic signed [15:0] cos_r;
  logic signed [31:0] sumx_r;
  logic signed [31:0] sumy_r;

  // integrator state
  logic signed [31:0] pos_x_r;
  logic signed [31:0] pos_y_r;
  logic [15:0]        heading_r;
  logic signed [31:0] pos_step_nxt;
  logic [15:0]        heading_nxt;
  logic signed [63:0] head_round;

  // output stage
  logic               out_valid_r;
  logic [127:0]       out_data_r;

  // shared units
  logic               in_fire;
  logic               out_free;
  ctrl_t              ctrl;
  logic [15:0]        rom_angle;
  logic signed [15:0] rom_q;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  poi_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctrl     (ctrl)
  );

  poi_sine_rom #(
    .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
  ) u_rom (
    .clk   (clk),
    .angle (rom_angle),
    .q     (rom_q)
  );

  poi_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // sine table address: old heading for the rotation, half the new heading for the quaternion
  always_comb begin
    case (ctrl.rom_src)
      ROM_HEAD:     rom_angle = heading_r;
      ROM_HEAD_COS: rom_angle = heading_r + QUARTER_TURN;
      ROM_HALF:     rom_angle = {1'b0, heading_r[15:1]};
      ROM_HALF_COS: rom_angle = {1'b0, heading_r[15:1]} + QUARTER_TURN;
      default:      rom_angle = heading_r;
    endcase
  end

  // multiplier operand select
  always_comb begin
    case (ctrl.mul_src)
      MUL_VX_COSQ: begin
        mul_a = 32'(vx_r);
        mul_b = 32'(rom_q);
      end
      MUL_VY_SIN: begin
        mul_a = 32'(vy_r);
        mul_b = 32'(sin_r);
      end
      MUL_VX_SIN: begin
        mul_a = 32'(vx_r);
        mul_b = 32'(sin_r);
      end
      MUL_VY_COS: begin
        mul_a = 32'(vy_r);
        mul_b = 32'(cos_r);
      end
      MUL_SX_DT: begin
        mul_a = sumx_r;
        mul_b = $signed({16'd0, dt_r});
      end
      MUL_SY_DT: begin
        mul_a = sumy_r;
        mul_b = $signed({16'd0, dt_r});
      end
      MUL_WZ_DT: begin
        mul_a = 32'(wz_r);
        mul_b = $signed({16'd0, dt_r});
      end
      MUL_P_K: begin
        // turn_rate * dt always fits 32 signed bits
        mul_a = $signed(prod[31:0]);
        mul_b = TURN_PER_RAD_Q16;
      end
      default: begin
        mul_a = 32'(vx_r);
        mul_b = 32'(rom_q);
      end
    endcase
  end

  // round the Q38 displacement half up to Q16 and add with saturation
  function automatic logic signed [31:0] pos_step(logic signed [31:0] pos,
                                                  logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [33:0] s;
    t = p + (64'sd1 <<< 21);
    s = 34'(pos) + $signed(t[55:22]);
    if (s > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (s < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return $signed(s[31:0]);
  endfunction

  always_comb begin
    if (ctrl.posx_upd) pos_step_nxt = pos_step(pos_x_r, prod);
    else               pos_step_nxt = pos_step(pos_y_r, prod);
  end

  // heading step rounded half up from Q44, wraps modulo one turn
  assign head_round  = prod + (64'sd1 <<< 43);
  assign heading_nxt = heading_r + head_round[59:44];

  // stale elapsed times fall back to the configured interval
  assign dt_nxt = (in_tdata[63:48] >= limit_r) ? fallback_r : in_tdata[63:48];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= 16'd32768;
      fallback_r <= 16'd6554;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL_LIMIT:    limit_r    <= cfg_wdata;
        REG_FALLBACK_INTERVAL: fallback_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // command capture and intermediate products
  always_ff @(posedge clk) begin
    if (in_fire) begin
      vx_r <= $signed(in_tdata[15:0]);
      vy_r <= $signed(in_tdata[31:16]);
      wz_r <= $signed(in_tdata[47:32]);
      dt_r <= dt_nxt;
    end
    if (ctrl.cap_sin)   sin_r  <= rom_q;
    if (ctrl.cap_cos)   cos_r  <= rom_q;
    if (ctrl.sumx_load) sumx_r <= prod[31:0];
    if (ctrl.sumx_sub)  sumx_r <= sumx_r - prod[31:0];
    if (ctrl.sumy_load) sumy_r <= prod[31:0];
    if (ctrl.sumy_add)  sumy_r <= sumy_r + prod[31:0];
  end

  // position and heading accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      heading_r <= '0;
    end else begin
      if (ctrl.posx_upd) pos_x_r   <= pos_step_nxt;
      if (ctrl.posy_upd) pos_y_r   <= pos_step_nxt;
      if (ctrl.head_upd) heading_r <= heading_nxt;
    end
  end

  // output register, loaded only when empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      // quat_z was captured last read, quat_w is the table output now
      out_data_r <= {dt_r, rom_q, sin_r, heading_r, pos_y_r, pos_x_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
